@@ hdl/sdtq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdtq_pkg
// Shared types and constants for the sorted deadline timer queue.
// ----------------------------------------------------------------------------
package sdtq_pkg;

	localparam int DEPTH       = 16;
	localparam int MAX_RESULTS = 16;

	localparam int DL_W   = 48;
	localparam int ID_W   = 31;
	localparam int TAG_W  = 8;
	localparam int SIZE_W = 5;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int RES_W  = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

	typedef enum logic [1:0] {
		OP_INSERT     = 2'd0,
		OP_TICK       = 2'd1,
		OP_REMOVE_ID  = 2'd2,
		OP_REMOVE_TAG = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		K_INSERTED     = 3'd0,
		K_FULL         = 3'd1,
		K_EXPIRED      = 3'd2,
		K_REMOVED      = 3'd3,
		K_NONE_EXPIRED = 3'd4,
		K_NONE_REMOVED = 3'd5
	} kind_t;

	typedef struct packed {
		logic [DL_W-1:0]  deadline;
		logic [ID_W-1:0]  timer_id;
		logic [TAG_W-1:0] instance_tag;
		logic             repeat_flag;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// what every cell does in the current cycle
	typedef enum logic [1:0] {
		CM_HOLD   = 2'd0,
		CM_INSERT = 2'd1,
		CM_POP    = 2'd2,
		CM_REMOVE = 2'd3
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t mode;
		logic       key_is_id;
		entry_t     new_entry;
	} cell_ctl_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} state_t;

endpackage
`default_nettype wire

@@ hdl/sdtq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdtq_cell
// One queue slot: holds an entry, shifts with its neighbors on insert,
// pop and removal.
// ----------------------------------------------------------------------------
module sdtq_cell import sdtq_pkg::*; (
	input  wire logic      clk,
	input  wire cell_ctl_t ctl,
	input  wire logic      occ,
	input  wire entry_t    left_entry,
	input  wire entry_t    right_entry,
	input  wire logic      link_in,
	input  wire logic      dup_in,
	output entry_t         entry,
	output logic           link_out,
	output logic           dup_out,
	output logic           first_hit
);

	entry_t entry_q;
	logic   take;
	logic   hit;
	logic   load_new;
	logic   load_left;
	logic   load_right;

	// free slots count as later than anything, keeping take monotonic
	assign take = !occ || (ctl.new_entry.deadline < entry_q.deadline);
	assign hit  = occ && (ctl.key_is_id ?
		(ctl.new_entry.timer_id == entry_q.timer_id) :
		(ctl.new_entry.instance_tag == entry_q.instance_tag));

	always_comb begin
		link_out   = 1'b0;
		dup_out    = 1'b0;
		first_hit  = 1'b0;
		load_new   = 1'b0;
		load_left  = 1'b0;
		load_right = 1'b0;
		case (ctl.mode)
			CM_INSERT: begin
				link_out  = take;
				load_new  = take && !link_in;
				load_left = take && link_in;
			end
			CM_POP: begin
				link_out   = link_in;
				load_right = link_in;
			end
			CM_REMOVE: begin
				link_out   = link_in || hit;
				dup_out    = dup_in || (link_in && hit);
				first_hit  = hit && !link_in;
				load_right = link_in || hit;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_new) begin
			entry_q <= ctl.new_entry;
		end else if (load_left) begin
			entry_q <= left_entry;
		end else if (load_right) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire

@@ hdl/sorted_deadline_timer_queue_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue_unit
// Timer queue kept sorted by deadline in a row of shifting cells.
// ----------------------------------------------------------------------------
// The command is registered at accept; each row step in the run state
//   then registers one result together with its strobe, and further results
//   of the same item follow one per cycle.
// Each item takes one cell-row step per result (an insert gives a single
//   result); busy drops with the last result.
// Reset: arst_n clears the entry count, the control state and the strobe;
//   entry contents stay unknown and are never read before written.
// The receiver cannot stall: every result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue_unit import sdtq_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        op,
	input  wire logic [DL_W-1:0]   deadline,
	input  wire logic [DL_W-1:0]   now,
	input  wire logic [ID_W-1:0]   timer_id,
	input  wire logic [TAG_W-1:0]  instance_tag,
	input  wire logic              repeat_req,
	output logic                   result_strobe,
	output logic [2:0]             kind,
	output logic [ID_W-1:0]        out_timer_id,
	output logic [TAG_W-1:0]       out_instance_tag,
	output logic                   out_repeat,
	output logic [SIZE_W-1:0]      queue_size,
	output logic                   last
);

	// command captured at accept
	state_t          state_q, state_d;
	op_t             op_q;
	entry_t          new_q;
	logic [DL_W-1:0] now_q;
	logic [RES_W-1:0] n_q;
	logic [CNT_W-1:0] count_q;

	// step decision for the current cycle
	cell_ctl_t        ctl;
	kind_t            step_kind;
	entry_t           step_entry;
	logic [CNT_W-1:0] step_size;
	logic             step_last;
	logic             accept;
	logic             at_cap;

	// result registers
	logic             strobe_q;
	kind_t            kind_q;
	entry_t           res_q;
	logic [CNT_W-1:0] size_q;
	logic             last_q;

	// cell row
	entry_t             cell_entry [DEPTH];
	logic [DEPTH:0]     link;
	logic [DEPTH:0]     dup;
	logic [DEPTH-1:0]   first_hit;
	logic [DEPTH-1:0]   occ;
	logic [ENTRY_W-1:0] hit_bits;
	entry_t             hit_entry;
	logic               head_due;
	logic               next_due;

	assign accept = start && !busy;
	assign at_cap = (n_q == RES_W'(MAX_RESULTS - 1));

	// pop chain is seeded at the head; insert and removal chains start empty
	assign link[0] = (ctl.mode == CM_POP);
	assign dup[0]  = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;

		assign occ[i] = (CNT_W'(i) < count_q);
		if (i == 0) begin : g_head
			assign left_e = '0;
		end else begin : g_mid
			assign left_e = cell_entry[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_e = '0;
		end else begin : g_body
			assign right_e = cell_entry[i+1];
		end

		sdtq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occ         (occ[i]),
			.left_entry  (left_e),
			.right_entry (right_e),
			.link_in     (link[i]),
			.dup_in      (dup[i]),
			.entry       (cell_entry[i]),
			.link_out    (link[i+1]),
			.dup_out     (dup[i+1]),
			.first_hit   (first_hit[i])
		);
	end

	// first_hit has at most one bit set, so an OR picks the removed entry
	always_comb begin
		hit_bits = '0;
		for (int i = 0; i < DEPTH; i++) begin
			hit_bits = hit_bits | ({ENTRY_W{first_hit[i]}} & cell_entry[i]);
		end
	end
	assign hit_entry = entry_t'(hit_bits);

	assign head_due = cell_entry[0].deadline < now_q;
	assign next_due = cell_entry[1].deadline < now_q;

	// row control: depends on registered state and head_due, never on the links
	always_comb begin
		ctl.mode      = CM_HOLD;
		ctl.key_is_id = (op_q == OP_REMOVE_ID);
		ctl.new_entry = new_q;
		if (state_q == ST_RUN) begin
			case (op_q)
				OP_INSERT: begin
					if (count_q < CNT_W'(DEPTH)) begin
						ctl.mode = CM_INSERT;
					end
				end
				OP_TICK: begin
					if ((count_q != '0) && head_due) begin
						ctl.mode = CM_POP;
					end
				end
				default: begin
					ctl.mode = CM_REMOVE;
				end
			endcase
		end
	end

	// one row step per cycle while running
	always_comb begin
		step_kind     = K_INSERTED;
		step_entry    = '0;
		step_size     = count_q;
		step_last     = 1'b1;
		case (op_q)
			OP_INSERT: begin
				if (count_q >= CNT_W'(DEPTH)) begin
					step_kind = K_FULL;
				end else begin
					step_kind = K_INSERTED;
					step_size = count_q + CNT_W'(1);
				end
			end
			OP_TICK: begin
				if ((count_q != '0) && head_due) begin
					step_kind  = K_EXPIRED;
					step_entry = cell_entry[0];
					step_size  = count_q - CNT_W'(1);
					step_last  = at_cap || (count_q == CNT_W'(1)) || !next_due;
				end else begin
					step_kind = K_NONE_EXPIRED;
				end
			end
			default: begin
				// removal by id or by tag; link[DEPTH] flags any match
				if (link[DEPTH]) begin
					step_kind  = K_REMOVED;
					step_entry = hit_entry;
					step_size  = count_q - CNT_W'(1);
					step_last  = at_cap || !dup[DEPTH];
				end else begin
					step_kind = K_NONE_REMOVED;
				end
			end
		endcase
		step_entry.deadline = '0;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (step_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		case (state_q)
			ST_RUN:  busy = 1'b1;
			default: busy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			n_q      <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= (state_q == ST_RUN);
			if (accept) begin
				n_q <= '0;
			end else if (state_q == ST_RUN) begin
				n_q     <= n_q + RES_W'(1);
				count_q <= step_size;
			end
		end
	end

	// command and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q                   <= op_t'(op);
			now_q                  <= now;
			new_q.deadline         <= deadline;
			new_q.timer_id         <= timer_id;
			new_q.instance_tag     <= instance_tag;
			new_q.repeat_flag      <= repeat_req;
		end
		if (state_q == ST_RUN) begin
			kind_q <= step_kind;
			res_q  <= step_entry;
			size_q <= step_size;
			last_q <= step_last;
		end
	end

	assign result_strobe    = strobe_q;
	assign kind             = kind_q;
	assign out_timer_id     = res_q.timer_id;
	assign out_instance_tag = res_q.instance_tag;
	assign out_repeat       = res_q.repeat_flag;
	assign queue_size       = SIZE_W'(size_q);
	assign last             = last_q;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_run_emits: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> result_strobe)
		else $error("row step without result");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last) |-> !busy)
		else $error("still busy after final result");

	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !last) |-> busy)
		else $error("item ended without final result");

endmodule
`default_nettype wire
